// ----- design/kar_pkg.sv -----
package kar_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 32;

  localparam logic [7:0] FMT_HVAL     = 8'h03;
  localparam logic [7:0] FMT_SVAL     = 8'h04;
  localparam logic [7:0] ATTR_CBANK   = 8'h0a;
  localparam logic [7:0] ATTR_PSIZE   = 8'h19;
  localparam logic [7:0] ATTR_PINFO   = 8'h17;
  localparam logic [7:0] ATTR_THREADS = 8'h05;
  localparam int unsigned WIDTH_SHIFT = 18;

  localparam logic [2:0] HDR_LEN  = 3'd4;
  localparam int unsigned PAY_KEEP = 12;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_BANK    = 3'd1;
  localparam logic [2:0] KIND_PSIZE   = 3'd2;
  localparam logic [2:0] KIND_ENTRY   = 3'd3;
  localparam logic [2:0] KIND_THREADS = 3'd4;
  localparam logic [2:0] KIND_IGNORED = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVERRUN = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  update_kind;
    logic [15:0] bank_base;
    logic [15:0] bank_size;
    logic [4:0]  entry_index;
    logic [15:0] entry_offset;
    logic [13:0] entry_width;
    logic [5:0]  entry_count;
    logic [31:0] thread_limit;
    logic        section_done;
    logic [1:0]  status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_acc;
    logic mul_lo;
    logic mul_hi;
    logic load_thr;
    logic move;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;
    logic thr_start;
  } dp_stat_t;

endpackage

// ----- design/kar_in_if.sv -----
interface kar_in_if;
  logic               valid;
  logic               ready;
  kar_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/kar_out_if.sv -----
interface kar_out_if;
  logic               valid;
  logic               ready;
  kar_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/kernel_attribute_record_parser_top.sv -----
// Takes one section byte per cycle while no max-threads result is being formed and the pending stage is free.
// The byte ending a max-threads record holds off further input while two 32x32
// multiplies run in turn on one multiplier stage each and the result is then formed.
// A pending stage and an output register sit between the parser and the result port.
// rst_n is synchronous, active low, and clears the control and parse state but not the result
// data registers; the parse state also clears after the result of the last byte of a section.
module kernel_attribute_record_parser_top #(
  parameter int unsigned MAX_ENTRIES = kar_pkg::MAX_ENTRIES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  kar_in_if.sink   in_item,
  kar_out_if.source out_item
);
  import kar_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  kar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kar_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_item.data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_item.data)
  );
endmodule

// ----- design/kar_ctrl.sv -----
module kar_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  kar_pkg::dp_stat_t stat,
  output kar_pkg::dp_cmd_t  cmd
);
  import kar_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL1 = 2'd1;
  localparam logic [1:0] S_MUL2 = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free, move, pend_free, accept, load_thr;

  assign slot_free = !out_valid_r || out_ready;
  assign move      = pend_valid_r && slot_free;
  assign pend_free = !pend_valid_r || move;
  assign in_ready  = (state_r == S_IDLE) && pend_free;
  assign accept    = in_valid && in_ready;
  assign load_thr  = (state_r == S_EMIT) && pend_free;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.load_acc = accept && stat.emit;
    cmd.mul_lo   = (state_r == S_MUL1);
    cmd.mul_hi   = (state_r == S_MUL2);
    cmd.load_thr = load_thr;
    cmd.move     = move;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && stat.thr_start) state_nxt = S_MUL1;
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_EMIT;
      S_EMIT: begin
        if (pend_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign pend_valid_nxt = (pend_valid_r && !move) || cmd.load_acc || load_thr;
  assign out_valid_nxt  = (out_valid_r && !out_ready) || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end
endmodule

// ----- design/kar_datapath.sv -----
module kar_datapath #(
  parameter int unsigned MAX_ENTRIES = kar_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kar_pkg::in_item_t  in_data,
  input  kar_pkg::dp_cmd_t   cmd,
  output kar_pkg::dp_stat_t  stat,
  output kar_pkg::out_item_t out_data
);
  import kar_pkg::*;

  localparam logic [15:0] ENT_LIMIT = 16'(MAX_ENTRIES);

  logic [2:0]  header_pos_r, header_pos_nxt;
  logic [7:0]  fmt_r, fmt_nxt;
  logic [7:0]  attr_r, attr_nxt;
  logic [15:0] value_r, value_nxt;
  logic [15:0] left_r, left_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  pay_r [PAY_KEEP];
  logic [7:0]  pay_nxt [PAY_KEEP];
  logic [15:0] base_r, base_nxt;
  logic [15:0] size_r, size_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [31:0] threads_r;
  logic        skip_r, skip_nxt;
  logic        last_r;
  logic [31:0] prod_r;
  out_item_t   pend_r, out_r, res_acc;

  logic        finish, thr_start, clr_acc, clr_thr;
  logic [1:0]  status_c;
  logic [2:0]  kind_c;
  logic [4:0]  idx_c;
  logic [15:0] off_c, plen, ord;
  logic [31:0] word_c;
  logic [13:0] wid_c;
  logic [8:0]  cnt_n;
  logic [5:0]  cnt_sat;
  logic [31:0] w0, w1, w2;

  assign w0 = {pay_r[3], pay_r[2], pay_r[1], pay_r[0]};
  assign w1 = {pay_r[7], pay_r[6], pay_r[5], pay_r[4]};
  assign w2 = {pay_r[11], pay_r[10], pay_r[9], pay_r[8]};

  always_comb begin
    header_pos_nxt = header_pos_r;
    fmt_nxt        = fmt_r;
    attr_nxt       = attr_r;
    value_nxt      = value_r;
    left_nxt       = left_r;
    pos_nxt        = pos_r;
    pay_nxt        = pay_r;
    base_nxt       = base_r;
    size_nxt       = size_r;
    count_nxt      = count_r;
    skip_nxt       = skip_r;
    finish         = 1'b0;
    status_c       = ST_OK;
    kind_c         = KIND_NONE;
    idx_c          = '0;
    off_c          = '0;
    wid_c          = '0;
    thr_start      = 1'b0;
    cnt_n          = '0;
    cnt_sat        = '0;

    if (skip_r) begin
      // drop bytes until the last one
    end else if (header_pos_r < HDR_LEN) begin
      case (header_pos_r)
        3'd0:    fmt_nxt = in_data.data_byte;
        3'd1:    attr_nxt = in_data.data_byte;
        3'd2:    value_nxt[7:0] = in_data.data_byte;
        default: value_nxt[15:8] = in_data.data_byte;
      endcase
      header_pos_nxt = header_pos_r + 3'd1;
      if (header_pos_nxt == HDR_LEN) begin
        left_nxt = (fmt_nxt == FMT_SVAL) ? value_nxt : 16'd0;
        pos_nxt  = '0;
        if (left_nxt == 16'd0) finish = 1'b1;
        else if (in_data.last_byte) status_c = ST_OVERRUN;
      end
    end else begin
      if (pos_r < 4'(PAY_KEEP)) begin
        pay_nxt[pos_r] = in_data.data_byte;
        pos_nxt        = pos_r + 4'd1;
      end
      left_nxt = left_r - 16'd1;
      if (left_nxt == 16'd0) finish = 1'b1;
      else if (in_data.last_byte) status_c = ST_OVERRUN;
    end

    plen   = (fmt_nxt == FMT_SVAL) ? value_nxt : 16'd0;
    ord    = {pay_nxt[5], pay_nxt[4]};
    word_c = {pay_nxt[11], pay_nxt[10], pay_nxt[9], pay_nxt[8]};

    if (finish) begin
      header_pos_nxt = '0;
      if (attr_nxt == ATTR_CBANK && plen >= 16'd8) begin
        base_nxt = ord;
        if (size_r == 16'd0) size_nxt = {pay_nxt[7], pay_nxt[6]};
        kind_c = KIND_BANK;
      end else if (attr_nxt == ATTR_PSIZE && fmt_nxt == FMT_HVAL) begin
        size_nxt = value_nxt;
        kind_c   = KIND_PSIZE;
      end else if (attr_nxt == ATTR_PINFO && plen >= 16'd12) begin
        if (ord >= ENT_LIMIT) begin
          status_c = ST_RANGE;
          if (!in_data.last_byte) skip_nxt = 1'b1;
        end else begin
          cnt_n   = ord[8:0] + 9'd1;
          cnt_sat = (cnt_n > 9'd63) ? 6'd63 : cnt_n[5:0];
          if (cnt_sat > count_r) count_nxt = cnt_sat;
          kind_c = KIND_ENTRY;
          idx_c  = ord[4:0];
          off_c  = {pay_nxt[7], pay_nxt[6]};
          wid_c  = word_c[WIDTH_SHIFT +: 14];
        end
      end else if (attr_nxt == ATTR_THREADS && plen >= 16'd12) begin
        thr_start = 1'b1;
      end else begin
        kind_c = KIND_IGNORED;
      end
    end
  end

  assign stat.thr_start = thr_start;
  assign stat.emit = !thr_start && (finish || status_c != ST_OK || in_data.last_byte);

  always_comb begin
    res_acc.update_kind  = kind_c;
    res_acc.bank_base    = base_nxt;
    res_acc.bank_size    = size_nxt;
    res_acc.entry_index  = idx_c;
    res_acc.entry_offset = off_c;
    res_acc.entry_width  = wid_c;
    res_acc.entry_count  = count_nxt;
    res_acc.thread_limit = threads_r;
    res_acc.section_done = in_data.last_byte;
    res_acc.status       = status_c;
  end

  // at a section end, a max-threads record clears only once its result is loaded into the pending stage
  assign clr_acc = cmd.accept && in_data.last_byte && !thr_start;
  assign clr_thr = cmd.load_thr && last_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr_acc || clr_thr) begin
      header_pos_r <= '0;
      fmt_r        <= '0;
      attr_r       <= '0;
      value_r      <= '0;
      left_r       <= '0;
      pos_r        <= '0;
      for (int i = 0; i < PAY_KEEP; i++) pay_r[i] <= '0;
      base_r       <= '0;
      size_r       <= '0;
      count_r      <= '0;
      threads_r    <= '0;
      skip_r       <= 1'b0;
    end else begin
      if (cmd.accept) begin
        header_pos_r <= header_pos_nxt;
        fmt_r        <= fmt_nxt;
        attr_r       <= attr_nxt;
        value_r      <= value_nxt;
        left_r       <= left_nxt;
        pos_r        <= pos_nxt;
        pay_r        <= pay_nxt;
        base_r       <= base_nxt;
        size_r       <= size_nxt;
        count_r      <= count_nxt;
        skip_r       <= skip_nxt;
      end
      if (cmd.mul_hi) threads_r <= prod_r * w2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) last_r <= in_data.last_byte;
    if (cmd.mul_lo) prod_r <= w0 * w1;
    if (cmd.load_acc) begin
      pend_r <= res_acc;
    end else if (cmd.load_thr) begin
      pend_r.update_kind  <= KIND_THREADS;
      pend_r.bank_base    <= base_r;
      pend_r.bank_size    <= size_r;
      pend_r.entry_index  <= '0;
      pend_r.entry_offset <= '0;
      pend_r.entry_width  <= '0;
      pend_r.entry_count  <= count_r;
      pend_r.thread_limit <= threads_r;
      pend_r.section_done <= last_r;
      pend_r.status       <= ST_OK;
    end
    if (cmd.move) out_r <= pend_r;
  end

  assign out_data = out_r;
endmodule
